// File: src/motor_current_protection_timer_unit_defines.svh
// Assertion macros for the motor current protection timer
`ifndef MOTOR_CURRENT_PROTECTION_TIMER_UNIT_DEFINES_SVH
`define MOTOR_CURRENT_PROTECTION_TIMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MCPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/mcpt_pkg.sv
`timescale 1ns / 1ps
package mcpt_pkg;

    localparam int unsigned VAL_W = 16;
    localparam int unsigned COMM_W = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    localparam logic [VAL_W-1:0] OC_THRESHOLD_RST  = 16'd15000;
    localparam logic [VAL_W-1:0] OC_TRIP_TICKS_RST = 16'd100;
    localparam logic [VAL_W-1:0] OC_HOLD_TICKS_RST = 16'd5000;
    localparam logic [VAL_W-1:0] OL_THRESHOLD_RST  = 16'd8000;
    localparam logic [VAL_W-1:0] OL_TRIP_TICKS_RST = 16'd5000;
    localparam logic [VAL_W-1:0] OL_HOLD_TICKS_RST = 16'd1000;
    localparam logic [VAL_W-1:0] SPEED_WINDOW_RST  = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OC_THRESHOLD  = 3'd0,
        CFG_OC_TRIP_TICKS = 3'd1,
        CFG_OC_HOLD_TICKS = 3'd2,
        CFG_OL_THRESHOLD  = 3'd3,
        CFG_OL_TRIP_TICKS = 3'd4,
        CFG_OL_HOLD_TICKS = 3'd5,
        CFG_SPEED_WINDOW  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [VAL_W-1:0]  current_sample;
        logic [COMM_W-1:0] commutations;
    } t_in_item;

    typedef struct packed {
        logic             over_current;
        logic             over_load;
        logic [VAL_W-1:0] speed;
        logic             speed_valid;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] threshold;
        logic [VAL_W-1:0] trip_ticks;
        logic [VAL_W-1:0] hold_ticks;
    } t_chan_cfg;

    typedef struct packed {
        logic [VAL_W-1:0] speed;
        logic             speed_valid;
    } t_speed_res;

endpackage

// File: src/mcpt_chan.sv
`timescale 1ns / 1ps
module mcpt_chan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [mcpt_pkg::VAL_W-1:0]   i_cur,
    input  mcpt_pkg::t_chan_cfg          i_cfg,
    output logic                         o_flag
);
    import mcpt_pkg::*;

    logic             r_flag;
    logic [VAL_W-1:0] r_cnt;
    logic             n_flag;
    logic [VAL_W-1:0] n_cnt;
    logic [VAL_W-1:0] cnt_inc;

    always_comb begin
        n_flag  = r_flag;
        n_cnt   = r_cnt;
        cnt_inc = (r_cnt != VAL_MAX) ? r_cnt + VAL_W'(1) : r_cnt;
        priority if (i_cur > i_cfg.threshold) begin
            if (!r_flag) begin
                if (cnt_inc > i_cfg.trip_ticks) begin
                    n_flag = 1'b1;
                    n_cnt  = i_cfg.hold_ticks;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
        end else if (!r_flag) begin
            n_cnt = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - VAL_W'(1);
        end else begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_cnt  <= '0;
        end else if (i_adv) begin
            r_flag <= n_flag;
            r_cnt  <= n_cnt;
        end
    end

    assign o_flag = n_flag;

endmodule

// File: src/mcpt_speed.sv
`timescale 1ns / 1ps
module mcpt_speed (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [mcpt_pkg::COMM_W-1:0]   i_comm,
    input  logic [mcpt_pkg::VAL_W-1:0]    i_window,
    output mcpt_pkg::t_speed_res          o_res
);
    import mcpt_pkg::*;

    logic [VAL_W-1:0] r_win;
    logic [VAL_W-1:0] r_sum;
    logic [VAL_W-1:0] r_latch;
    logic [VAL_W-1:0] n_win;
    logic [VAL_W-1:0] n_sum;
    logic [VAL_W-1:0] n_latch;
    logic             n_valid;
    logic [VAL_W:0]   sum_wide;
    logic [VAL_W-1:0] sum_sat;

    always_comb begin
        sum_wide = {1'b0, r_sum} + (VAL_W+1)'(i_comm);
        sum_sat  = sum_wide[VAL_W] ? VAL_MAX : sum_wide[VAL_W-1:0];
        if (r_win >= i_window) begin
            n_win   = '0;
            n_sum   = '0;
            n_latch = sum_sat;
            n_valid = 1'b1;
        end else begin
            n_win   = r_win + VAL_W'(1);
            n_sum   = sum_sat;
            n_latch = r_latch;
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_sum   <= '0;
            r_latch <= '0;
        end else if (i_adv) begin
            r_win   <= n_win;
            r_sum   <= n_sum;
            r_latch <= n_latch;
        end
    end

    assign o_res.speed       = n_latch;
    assign o_res.speed_valid = n_valid;

endmodule

// File: src/motor_current_protection_timer_unit.sv
// An accepted request waits in the input register and moves to the result register when that is free.
// Throughput: one request per cycle while results are taken; input register and result register run as a
// two-stage pipeline, the result register frees as soon as the result is taken.
// Reset (synchronous, active low): thresholds, trip and hold times and window load
// their defaults; flags, counters, sum and latched speed clear; both stages empty.
`timescale 1ns / 1ps
`include "motor_current_protection_timer_unit_defines.svh"
module motor_current_protection_timer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mcpt_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mcpt_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mcpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mcpt_pkg::VAL_W-1:0]       i_cfg_data
);
    import mcpt_pkg::*;

    t_chan_cfg        r_oc_cfg;
    t_chan_cfg        r_ol_cfg;
    logic [VAL_W-1:0] r_speed_window;

    t_in_item         r_in;
    logic             r_in_vld;
    t_out_item        r_out;
    logic             r_out_vld;

    logic             s2_load;
    logic             adv;
    logic             in_acc;
    logic             oc_flag;
    logic             ol_flag;
    t_speed_res       speed_res;

    assign s2_load    = !r_out_vld || i_out_ready;
    assign adv        = r_in_vld && s2_load;
    assign o_in_ready = !r_in_vld || s2_load;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_cfg       <= '{OC_THRESHOLD_RST, OC_TRIP_TICKS_RST, OC_HOLD_TICKS_RST};
            r_ol_cfg       <= '{OL_THRESHOLD_RST, OL_TRIP_TICKS_RST, OL_HOLD_TICKS_RST};
            r_speed_window <= SPEED_WINDOW_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OC_THRESHOLD:  r_oc_cfg.threshold  <= i_cfg_data;
                CFG_OC_TRIP_TICKS: r_oc_cfg.trip_ticks <= i_cfg_data;
                CFG_OC_HOLD_TICKS: r_oc_cfg.hold_ticks <= i_cfg_data;
                CFG_OL_THRESHOLD:  r_ol_cfg.threshold  <= i_cfg_data;
                CFG_OL_TRIP_TICKS: r_ol_cfg.trip_ticks <= i_cfg_data;
                CFG_OL_HOLD_TICKS: r_ol_cfg.hold_ticks <= i_cfg_data;
                CFG_SPEED_WINDOW:  r_speed_window      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    mcpt_chan u_oc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cur   (r_in.current_sample),
        .i_cfg   (r_oc_cfg),
        .o_flag  (oc_flag)
    );

    mcpt_chan u_ol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cur   (r_in.current_sample),
        .i_cfg   (r_ol_cfg),
        .o_flag  (ol_flag)
    );

    mcpt_speed u_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_comm   (r_in.commutations),
        .i_window (r_speed_window),
        .o_res    (speed_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.over_current <= oc_flag;
            r_out.over_load    <= ol_flag;
            r_out.speed        <= speed_res.speed;
            r_out.speed_valid  <= speed_res.speed_valid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `MCPT_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, r_in_vld && !r_out_vld, r_out_vld, "request in input stage did not reach result register")
    `MCPT_ASSERT_SAME(a_ready_full, i_clk, i_rst_n, !o_in_ready, r_in_vld && r_out_vld, "ready low without both stages full")
    `MCPT_ASSERT_NEXT(a_acc_held, i_clk, i_rst_n, in_acc, r_in_vld, "accepted request not held in input stage")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mcpt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

    class status_scoreboard;
        t_chan_cfg        oc_cfg;
        t_chan_cfg        ol_cfg;
        logic [VAL_W-1:0] window_end;
        logic             oc_flag;
        logic             ol_flag;
        logic [VAL_W-1:0] oc_count;
        logic [VAL_W-1:0] ol_count;
        logic [VAL_W-1:0] window_count;
        logic [VAL_W-1:0] comm_sum;
        logic [VAL_W-1:0] speed_hold;
        t_out_item        pending_q[$];
        int               errors;

        function new();
            oc_cfg = '{threshold: OC_THRESHOLD_RST, trip_ticks: OC_TRIP_TICKS_RST,
                       hold_ticks: OC_HOLD_TICKS_RST};
            ol_cfg = '{threshold: OL_THRESHOLD_RST, trip_ticks: OL_TRIP_TICKS_RST,
                       hold_ticks: OL_HOLD_TICKS_RST};
            window_end   = SPEED_WINDOW_RST;
            oc_flag      = 1'b0;
            ol_flag      = 1'b0;
            oc_count     = '0;
            ol_count     = '0;
            window_count = '0;
            comm_sum     = '0;
            speed_hold   = '0;
            errors       = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
            case (idx)
                CFG_OC_THRESHOLD:  oc_cfg.threshold  = val;
                CFG_OC_TRIP_TICKS: oc_cfg.trip_ticks = val;
                CFG_OC_HOLD_TICKS: oc_cfg.hold_ticks = val;
                CFG_OL_THRESHOLD:  ol_cfg.threshold  = val;
                CFG_OL_TRIP_TICKS: ol_cfg.trip_ticks = val;
                CFG_OL_HOLD_TICKS: ol_cfg.hold_ticks = val;
                CFG_SPEED_WINDOW:  window_end        = val;
                default: ;
            endcase
        endfunction

        function void step_channel(input logic [VAL_W-1:0] cur, input t_chan_cfg c,
                                   inout logic flag, inout logic [VAL_W-1:0] cnt);
            if (cur > c.threshold) begin
                if (!flag) begin
                    if (cnt != VAL_MAX) cnt = cnt + 1'b1;
                    if (cnt > c.trip_ticks) begin
                        flag = 1'b1;
                        cnt  = c.hold_ticks;
                    end
                end
            end else if (!flag) begin
                cnt = '0;
            end else if (cnt != '0) begin
                cnt = cnt - 1'b1;
            end else begin
                flag = 1'b0;
            end
        endfunction

        function void note_tick(input t_in_item it);
            logic [VAL_W:0] sum;
            t_out_item      exp;
            sum = {1'b0, comm_sum} + (VAL_W+1)'(it.commutations);
            comm_sum = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
            exp.speed_valid = 1'b0;
            if (window_count >= window_end) begin
                window_count    = '0;
                speed_hold      = comm_sum;
                comm_sum        = '0;
                exp.speed_valid = 1'b1;
            end else begin
                window_count = window_count + 1'b1;
            end
            step_channel(it.current_sample, oc_cfg, oc_flag, oc_count);
            step_channel(it.current_sample, ol_cfg, ol_flag, ol_count);
            exp.over_current = oc_flag;
            exp.over_load    = ol_flag;
            exp.speed        = speed_hold;
            pending_q.push_back(exp);
        endfunction

        task report(input string msg);
            $display("%0t tb_top mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_status(input t_out_item got);
            t_out_item exp;
            if (pending_q.size() == 0) begin
                report("result with no pending request");
                return;
            end
            exp = pending_q.pop_front();
            if (got.over_current !== exp.over_current)
                report($sformatf("over_current got %0b exp %0b",
                                 got.over_current, exp.over_current));
            if (got.over_load !== exp.over_load)
                report($sformatf("over_load got %0b exp %0b", got.over_load, exp.over_load));
            if (got.speed !== exp.speed)
                report($sformatf("speed got %0d exp %0d", got.speed, exp.speed));
            if (got.speed_valid !== exp.speed_valid)
                report($sformatf("speed_valid got %0b exp %0b",
                                 got.speed_valid, exp.speed_valid));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VAL_W-1:0]     i_cfg_data;

    status_scoreboard sb;
    bit               in_idle_en;
    bit               out_idle_en;
    bit               pressure_req;
    logic [VAL_W-1:0] oc_thr_now;
    logic [VAL_W-1:0] ol_thr_now;

    motor_current_protection_timer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int pick_gap(input bit en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] rand_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 12) return VAL_MAX;
        if (r < 15) return VAL_MAX - 1'b1;
        if (r < 80) return VAL_W'($urandom_range(1, 12));
        return VAL_W'($urandom);
    endfunction

    function automatic logic [VAL_W-1:0] rand_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return VAL_MAX;
        return VAL_W'($urandom);
    endfunction

    task automatic send_tick(input logic [VAL_W-1:0] cur, input logic [COMM_W-1:0] comm);
        t_in_item it;
        int       gap;
        it.current_sample = cur;
        it.commutations   = comm;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_tick(it);
        @(negedge i_clk);
        gap = pick_gap(in_idle_en);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        if (idx == CFG_OC_THRESHOLD) oc_thr_now = val;
        if (idx == CFG_OL_THRESHOLD) ol_thr_now = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input bit with_pressure);
        int               left;
        int               cat;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] cur;
        end_burst();
        drain();
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OC_THRESHOLD, rand_level());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OC_TRIP_TICKS, rand_ticks());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OC_HOLD_TICKS, rand_ticks());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OL_THRESHOLD, rand_level());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OL_TRIP_TICKS, rand_ticks());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_OL_HOLD_TICKS, rand_ticks());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_SPEED_WINDOW, rand_ticks());
        if ($urandom_range(0, 9) == 0) set_reg(CFG_IDX_NONE, VAL_W'($urandom));
        in_idle_en  = with_pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
        if (with_pressure) pressure_req = 1'b1;
        lo = int'((oc_thr_now < ol_thr_now) ? oc_thr_now : ol_thr_now);
        hi = int'((oc_thr_now < ol_thr_now) ? ol_thr_now : oc_thr_now);
        left = 0;
        cat  = 0;
        for (int i = 0; i < n; i++) begin
            if (left == 0) begin
                cat  = $urandom_range(0, 9);
                left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 15);
            end
            left--;
            // noise on about 1 tick in 5, otherwise runs within one band
            if (cat == 9 || $urandom_range(0, 9) == 0) begin
                cur = VAL_W'($urandom);
            end else if (cat < 3) begin
                cur = VAL_W'($urandom_range(0, lo));
            end else if (cat < 5 && lo < hi) begin
                cur = VAL_W'($urandom_range(lo + 1, hi));
            end else if (cat < 8 && hi < 65535) begin
                cur = VAL_W'($urandom_range(hi + 1, 65535));
            end else begin
                cur = $urandom_range(0, 1) ? VAL_W'(lo) : VAL_W'(hi);
            end
            send_tick(cur, COMM_W'($urandom));
        end
    endtask

    initial begin
        int               stall_left;
        int               run_left;
        int               hold_left;
        i_out_ready = 1'b0;
        stall_left  = 0;
        run_left    = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!out_idle_en) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                i_out_ready <= 1'b1;
            end else begin
                run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 4);
                stall_left = pick_gap(1'b1);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_status(o_out_data);
        end
    end

    initial begin
        #20000000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        pressure_req = 1'b0;
        oc_thr_now   = OC_THRESHOLD_RST;
        ol_thr_now   = OL_THRESHOLD_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults, field extremes
        send_tick('0, '0);
        send_tick(VAL_MAX, 4'hF);
        send_tick(16'd15000, 4'd1);
        send_tick(16'd15001, 4'd2);
        end_burst();
        drain();

        // fast trip, zero hold, window of one tick, ignored index
        set_reg(CFG_OC_THRESHOLD, 16'd100);
        set_reg(CFG_OC_TRIP_TICKS, 16'd2);
        set_reg(CFG_OC_HOLD_TICKS, 16'd0);
        set_reg(CFG_OL_THRESHOLD, VAL_MAX);
        set_reg(CFG_OL_TRIP_TICKS, 16'd0);
        set_reg(CFG_OL_HOLD_TICKS, 16'd3);
        set_reg(CFG_SPEED_WINDOW, 16'd0);
        set_reg(CFG_IDX_NONE, VAL_MAX);
        repeat (4) send_tick(16'd200, 4'hF);
        send_tick(VAL_MAX, 4'h5);
        send_tick(16'd100, 4'hA);
        send_tick('0, '0);
        end_burst();
        drain();

        set_reg(CFG_OL_THRESHOLD, 16'd0);
        send_tick(16'd1, 4'd3);
        repeat (5) send_tick('0, 4'd1);
        end_burst();
        drain();

        // window lowered below the running count
        set_reg(CFG_SPEED_WINDOW, 16'd40);
        repeat (8) send_tick(16'd50, 4'd7);
        end_burst();
        drain();
        set_reg(CFG_SPEED_WINDOW, 16'd3);
        repeat (2) send_tick(16'd50, 4'd7);
        end_burst();
        drain();

        // long window, back to back requests
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        set_reg(CFG_OC_THRESHOLD, VAL_MAX);
        set_reg(CFG_OL_THRESHOLD, VAL_MAX);
        set_reg(CFG_OC_HOLD_TICKS, 16'd1);
        set_reg(CFG_OL_HOLD_TICKS, 16'd1);
        set_reg(CFG_SPEED_WINDOW, 16'd4500);
        repeat (12) send_tick(VAL_W'($urandom), 4'hF);
        end_burst();
        drain();

        // trip times at the top of the range
        set_reg(CFG_OC_THRESHOLD, 16'd0);
        set_reg(CFG_OL_THRESHOLD, 16'd0);
        set_reg(CFG_OC_TRIP_TICKS, VAL_MAX - 1'b1);
        set_reg(CFG_OL_TRIP_TICKS, VAL_MAX);
        set_reg(CFG_OC_HOLD_TICKS, 16'd2);
        set_reg(CFG_SPEED_WINDOW, VAL_MAX);
        repeat (10) send_tick(VAL_W'($urandom_range(1, 65535)), COMM_W'($urandom));
        repeat (5) send_tick('0, COMM_W'($urandom));
        end_burst();
        drain();

        for (int p = 0; p < 12; p++) run_phase(66, p == 2);
        end_burst();
        drain();
        repeat (6) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
